FILE: sv/mppa_pkg.sv
// Shared types, codes and constants of the multi-pool page allocator.
package mppa_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 64;
  localparam int SLOT_CFG_W = 7;
  localparam int PAGES_W    = 9;
  localparam int CFG_POOLS  = 7;

  localparam logic [2:0] STACK_POOL = 3'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_POOL = 2'd2,
    ST_OUTSIDE = 2'd3
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    CFG_REGION_BASE        = 3'd0,
    CFG_KERNEL_TABLE_SLOTS = 3'd1,
    CFG_TASK_SLOTS         = 3'd2,
    CFG_STACK_SLOTS        = 3'd3,
    CFG_SPACE_RECORD_SLOTS = 3'd4,
    CFG_USER_TABLE_SLOTS   = 3'd5,
    CFG_AREA_SLOTS         = 3'd6,
    CFG_FILE_SLOTS         = 3'd7
  } cfg_index_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]     base;
    logic [SLOT_CFG_W-1:0] count;
  } pool_geom_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  no_pool;
    logic                  stack;
    logic [ADDR_W-1:0]     base;
    logic [ADDR_W-1:0]     addr;
    logic [SLOT_CFG_W-1:0] count;
  } req_ctx_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] page_address;
    status_t           status;
  } slot_res_t;

endpackage

FILE: sv/mppa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mppa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 7,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/mppa_layout.sv
// Configuration registers and pool geometry (base address and slot count).
module mppa_layout #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [2:0]                 cfg_index,
  input  logic [63:0]                cfg_data,
  input  logic [2:0]                 pool,
  output mppa_pkg::pool_geom_t       geom
);

  logic [63:0] region_base;
  logic [mppa_pkg::SLOT_CFG_W-1:0] slots [mppa_pkg::CFG_POOLS];
  logic [mppa_pkg::SLOT_CFG_W-1:0] sat   [mppa_pkg::CFG_POOLS];
  logic [mppa_pkg::PAGES_W-1:0]    pages;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      for (int i = 0; i < mppa_pkg::CFG_POOLS; i++) begin
        slots[i] <= 7'd64;
      end
    end else if (cfg_write) begin
      case (mppa_pkg::cfg_index_t'(cfg_index))
        mppa_pkg::CFG_REGION_BASE:        region_base <= cfg_data;
        mppa_pkg::CFG_KERNEL_TABLE_SLOTS: slots[0] <= cfg_data[6:0];
        mppa_pkg::CFG_TASK_SLOTS:         slots[1] <= cfg_data[6:0];
        mppa_pkg::CFG_STACK_SLOTS:        slots[2] <= cfg_data[6:0];
        mppa_pkg::CFG_SPACE_RECORD_SLOTS: slots[3] <= cfg_data[6:0];
        mppa_pkg::CFG_USER_TABLE_SLOTS:   slots[4] <= cfg_data[6:0];
        mppa_pkg::CFG_AREA_SLOTS:         slots[5] <= cfg_data[6:0];
        mppa_pkg::CFG_FILE_SLOTS:         slots[6] <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Clamp each pool to the bitmap width, then sum the pools below the request.
  always_comb begin
    for (int i = 0; i < mppa_pkg::CFG_POOLS; i++) begin
      sat[i] = (slots[i] > 7'(MAX_SLOTS)) ? 7'(MAX_SLOTS) : slots[i];
    end
  end

  always_comb begin
    pages = '0;
    for (int q = 0; q < mppa_pkg::CFG_POOLS; q++) begin
      if (3'(q) < pool) begin
        pages = pages + mppa_pkg::PAGES_W'(sat[q]);
      end
    end
  end

  always_comb begin
    geom.base  = region_base + (64'(pages) << mppa_pkg::PAGE_SHIFT);
    geom.count = (pool < 3'(mppa_pkg::CFG_POOLS)) ? sat[pool] : '0;
  end

endmodule

FILE: sv/mppa_slot_unit.sv
// Bitmap modify step: lowest free slot for allocate, slot clear for free.
module mppa_slot_unit #(
  parameter int MAX_SLOTS = 64
) (
  input  mppa_pkg::req_ctx_t     ctx,
  input  logic [MAX_SLOTS-1:0]   map_in,
  output logic [MAX_SLOTS-1:0]   map_out,
  output mppa_pkg::slot_res_t    res
);

  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [MAX_SLOTS-1:0] avail;
  logic                 found;
  logic [SW-1:0]        idx;
  logic [6:0]           slot_pages;
  logic [63:0]          rel;
  logic                 outside;
  logic [SW-1:0]        free_idx;

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      avail[i] = !map_in[i] && (7'(i) < ctx.count);
    end
  end

  // Priority search from the top so the lowest free slot wins.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        found = 1'b1;
        idx   = SW'(i);
      end
    end
  end

  assign slot_pages = 7'(idx) + 7'(ctx.stack);
  assign rel        = ctx.addr - ctx.base;
  assign outside    = rel[63:mppa_pkg::PAGE_SHIFT] >= 52'(ctx.count);
  assign free_idx   = rel[mppa_pkg::PAGE_SHIFT +: SW];

  always_comb begin
    map_out          = map_in;
    res.wr_en        = 1'b0;
    res.page_address = '0;
    res.status       = mppa_pkg::ST_OK;
    if (ctx.no_pool) begin
      res.status = mppa_pkg::ST_NO_POOL;
    end else if (ctx.mode == mppa_pkg::MODE_ALLOC) begin
      if (!found) begin
        res.status = mppa_pkg::ST_FULL;
      end else begin
        res.wr_en        = 1'b1;
        map_out          = map_in | (MAX_SLOTS'(1) << idx);
        res.page_address = ctx.base + (64'(slot_pages) << mppa_pkg::PAGE_SHIFT);
      end
    end else begin
      if (outside) begin
        res.status = mppa_pkg::ST_OUTSIDE;
      end else begin
        res.wr_en = 1'b1;
        map_out   = map_in & ~(MAX_SLOTS'(1) << free_idx);
      end
    end
  end

endmodule

FILE: sv/multi_pool_page_allocator.sv
// Multi-pool bitmap page allocator, top level with control and output register.
// A request is captured with its bitmap read when accepted, then modified in the execute
// state and written to the output register; a result stalled at the output holds it there.
// The pool bitmap memory is read-modify-written per request (read on accept, modify
// and write back in the execute state), so no new request is taken until that is done.
// Reset: config returns to base 0 and 64 slots per pool; per-pool valid bits make
// every bitmap read as all free at once, so there is no clearing pass.
module multi_pool_page_allocator #(
  parameter int MAX_SLOTS  = 64,
  parameter int POOL_COUNT = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [2:0]  pool,
  input  logic [63:0] free_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] page_address,
  output logic [1:0]  status
);

  localparam int AW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;

  mppa_pkg::state_t     state, state_next;
  mppa_pkg::pool_geom_t geom;
  mppa_pkg::req_ctx_t   ctx;
  mppa_pkg::slot_res_t  res;

  logic                  in_accept;
  logic                  exec_done;
  logic                  no_pool;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [POOL_COUNT-1:0] map_valid;
  logic                  entry_valid;
  logic [MAX_SLOTS-1:0]  rd_data;
  logic [MAX_SLOTS-1:0]  map_in;
  logic [MAX_SLOTS-1:0]  map_out;

  mppa_layout #(.MAX_SLOTS(MAX_SLOTS)) u_layout (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pool      (pool),
    .geom      (geom)
  );

  mppa_ram #(.WIDTH(MAX_SLOTS), .DEPTH(POOL_COUNT)) u_map_ram (
    .clk     (clk),
    .wr_en   (exec_done && res.wr_en),
    .wr_addr (wr_addr),
    .wr_data (map_out),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mppa_slot_unit #(.MAX_SLOTS(MAX_SLOTS)) u_slot (
    .ctx     (ctx),
    .map_in  (map_in),
    .map_out (map_out),
    .res     (res)
  );

  assign no_pool   = pool >= 3'(POOL_COUNT);
  assign rd_addr   = no_pool ? '0 : pool[AW-1:0];
  assign in_accept = in_valid && !in_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mppa_pkg::S_IDLE: if (in_accept) state_next = mppa_pkg::S_EXEC;
      mppa_pkg::S_EXEC: if (exec_done) state_next = mppa_pkg::S_IDLE;
      default:          state_next = mppa_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall  = 1'b1;
    exec_done = 1'b0;
    case (state)
      mppa_pkg::S_IDLE: in_stall  = 1'b0;
      mppa_pkg::S_EXEC: exec_done = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mppa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request with its pool geometry; stack pool frees drop the end offset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ctx.mode    <= mppa_pkg::mode_t'(mode);
      ctx.no_pool <= no_pool;
      ctx.stack   <= pool == mppa_pkg::STACK_POOL;
      ctx.base    <= geom.base;
      ctx.count   <= geom.count;
      ctx.addr    <= (pool == mppa_pkg::STACK_POOL) ?
                     free_address - 64'(mppa_pkg::PAGE_BYTES) : free_address;
      wr_addr     <= rd_addr;
      entry_valid <= map_valid[rd_addr];
    end
  end

  // An entry never written since reset reads as all slots free.
  assign map_in = entry_valid ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= '0;
    end else if (exec_done && res.wr_en) begin
      map_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      page_address <= res.page_address;
      status       <= res.status;
    end
  end

endmodule

FILE: dv/page_alloc_checker.sv
// Checker for the page allocator: shadows the pool maps, predicts each result and compares it.
module page_alloc_checker
  import mppa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        mode,
  input  logic [2:0]  pool,
  input  logic [63:0] free_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] page_address,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          outstanding,
  output int          results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_LIMIT = 64;

  typedef struct packed {
    logic [63:0] page;
    status_t     status;
  } page_result_t;

  logic [63:0]  region_base;
  logic [6:0]   slot_cfg [CFG_POOLS];
  logic [63:0]  used_map [CFG_POOLS];
  page_result_t pending_pages [$];
  int           errors = 0;
  int           checked = 0;

  function automatic logic [63:0] pool_size(input int p);
    return (slot_cfg[p] > SLOT_LIMIT) ? 64'(SLOT_LIMIT) : 64'(slot_cfg[p]);
  endfunction

  // Pools sit back to back; offsets wrap at 2^64.
  function automatic logic [63:0] pool_start(input int p);
    logic [63:0] b;
    b = region_base;
    for (int q = 0; q < p; q++) b = b + (pool_size(q) << PAGE_SHIFT);
    return b;
  endfunction

  function automatic page_result_t next_page(input mode_t m, input logic [2:0] p,
                                             input logic [63:0] a);
    page_result_t r;
    logic [63:0]  n;
    logic [63:0]  start;
    logic [63:0]  slot;
    logic         found;
    r.page   = '0;
    r.status = ST_OK;
    if (p >= CFG_POOLS) begin
      r.status = ST_NO_POOL;
      return r;
    end
    n     = pool_size(p);
    start = pool_start(p);
    if (m == MODE_ALLOC) begin
      found = 1'b0;
      slot  = '0;
      // Scan downward so the last hit is the lowest free slot.
      for (int s = SLOT_LIMIT - 1; s >= 0; s--) begin
        if (64'(s) < n && !used_map[p][s]) begin
          found = 1'b1;
          slot  = 64'(s);
        end
      end
      if (!found) begin
        r.status = ST_FULL;
      end else begin
        used_map[p][slot[5:0]] = 1'b1;
        r.page = start + (slot << PAGE_SHIFT) + ((p == STACK_POOL) ? 64'(PAGE_BYTES) : 64'd0);
      end
    end else begin
      if (p == STACK_POOL) a = a - 64'(PAGE_BYTES);
      slot = (a - start) >> PAGE_SHIFT;
      if (slot >= n) r.status = ST_OUTSIDE;
      else used_map[p][slot[5:0]] = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] allocator mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    page_result_t want;
    if (rst) begin
      region_base = '0;
      for (int p = 0; p < CFG_POOLS; p++) begin
        slot_cfg[p] = 7'd64;
        used_map[p] = '0;
      end
      pending_pages.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_pages.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction: page %h status %0d",
                                    page_address, status));
        end else begin
          want = pending_pages.pop_front();
          checked++;
          if (page_address !== want.page)
            report_mismatch($sformatf("page_address %h, expected %h", page_address, want.page));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_REGION_BASE: region_base = cfg_data;
          default:         slot_cfg[int'(cfg_index) - 1] = cfg_data[6:0];
        endcase
      end
      if (in_valid && !in_stall)
        pending_pages.push_back(next_page(mode_t'(mode), pool, free_address));
    end
    fail_count      <= errors;
    outstanding     <= pending_pages.size();
    results_checked <= checked;
  end

endmodule

FILE: dv/tb.sv
// Testbench top: drives pool layouts and page requests into the allocator and gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mppa_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [2:0]  pool;
  logic [63:0] free_address;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] page_address;
  logic [1:0]  status;
  int          fail_count;
  int          outstanding;
  int          results_checked;

  logic        quiet = 1'b0;
  logic [63:0] layout_origin;
  logic [6:0]  layout_slots [CFG_POOLS];
  int          alloc_pct;
  int          focus_pool;
  int          requests_sent = 0;
  int          layouts_run = 0;

  multi_pool_page_allocator dut (.*);

  page_alloc_checker alloc_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) out_stall <= !quiet && ($urandom_range(99) < 20);

  function automatic logic [63:0] layout_pages(input int p);
    return (layout_slots[p] > 64) ? 64'd64 : 64'(layout_slots[p]);
  endfunction

  function automatic logic [63:0] layout_start(input int p);
    logic [63:0] b;
    b = layout_origin;
    for (int q = 0; q < p; q++) b = b + (layout_pages(q) << PAGE_SHIFT);
    return b;
  endfunction

  function automatic logic [6:0] random_slots();
    int k;
    k = $urandom_range(99);
    if (k < 10) return 7'd0;
    if (k < 20) return 7'd64;
    if (k < 25) return 7'($urandom_range(127, 65));
    if (k < 60) return 7'($urandom_range(4, 1));
    return 7'($urandom_range(16, 5));
  endfunction

  // Hold the payload until the transaction is taken; valid stays up for back-to-back requests.
  task automatic push_request(input mode_t m, input logic [2:0] p, input logic [63:0] a);
    if (!quiet && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    pool         <= p;
    free_address <= a;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Junk in the upper data bits of a slot register must be ignored.
  task automatic load_layout();
    cfg_write <= 1'b1;
    cfg_index <= CFG_REGION_BASE;
    cfg_data  <= layout_origin;
    @(posedge clk);
    for (int p = 0; p < CFG_POOLS; p++) begin
      cfg_index <= cfg_index_t'(p + 1);
      cfg_data  <= {$urandom, 25'($urandom), layout_slots[p]};
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    layouts_run++;
  endtask

  task automatic random_request();
    mode_t       m;
    logic [2:0]  p;
    logic [63:0] a;
    logic [63:0] start;
    logic [63:0] pages;
    int          k;
    k = $urandom_range(99);
    if (k < 5) p = 3'd7;
    else if (k < 45) p = 3'(focus_pool);
    else p = 3'($urandom_range(CFG_POOLS - 1));
    m = ($urandom_range(99) < alloc_pct) ? MODE_ALLOC : MODE_FREE;
    a = {$urandom, $urandom};
    if (m == MODE_FREE && p < CFG_POOLS) begin
      start = layout_start(p);
      pages = layout_pages(p);
      k = $urandom_range(99);
      if (k < 80 && pages != 0) begin
        a = start + (64'($urandom_range(int'(pages) - 1)) << PAGE_SHIFT);
        if ($urandom_range(2) == 0) a = a + $urandom_range(PAGE_BYTES - 1);
      end else if (k < 90) begin
        a = start + (pages << PAGE_SHIFT);
      end else if (k < 95) begin
        a = start - 1;
      end
      if (p == STACK_POOL && k < 90) a = a + PAGE_BYTES;
    end
    push_request(m, p, a);
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= CFG_REGION_BASE;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    mode         <= MODE_ALLOC;
    pool         <= '0;
    free_address <= '0;
    layout_origin = '0;
    for (int p = 0; p < CFG_POOLS; p++) layout_slots[p] = 7'd64;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Power-on layout: base 0, every pool 64 pages.
    push_request(MODE_ALLOC, 3'd0, '0);
    push_request(MODE_ALLOC, 3'd0, '1);
    push_request(MODE_ALLOC, STACK_POOL, '0);
    push_request(MODE_ALLOC, 3'd6, '0);
    push_request(MODE_ALLOC, 3'd7, '0);
    push_request(MODE_FREE, 3'd7, '1);
    push_request(MODE_FREE, STACK_POOL, layout_start(STACK_POOL) + PAGE_BYTES);
    push_request(MODE_FREE, STACK_POOL, layout_start(STACK_POOL));
    push_request(MODE_FREE, 3'd0, 64'h1FFF);
    push_request(MODE_FREE, 3'd0, 64'h1000);
    push_request(MODE_FREE, 3'd1, '0);
    push_request(MODE_FREE, 3'd6, layout_start(6) + (64'd64 << PAGE_SHIFT));
    push_request(MODE_FREE, 3'd6, layout_start(6) + (64'd64 << PAGE_SHIFT) - 1);
    push_request(MODE_FREE, 3'd3, '1);
    push_request(MODE_ALLOC, 3'd0, '0);
    push_request(MODE_ALLOC, 3'd1, '0);
    push_request(MODE_ALLOC, 3'd3, '0);
    push_request(MODE_ALLOC, 3'd4, '0);
    push_request(MODE_ALLOC, 3'd5, '0);
    push_request(MODE_FREE, 3'd4, layout_start(4));

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin
          layout_origin = '1;
          layout_slots  = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd2, 7'd3, 7'd64};
        end
        1: begin
          layout_origin = 64'hFFFF_FFFF_FFF8_0000;
          for (int p = 0; p < CFG_POOLS; p++) layout_slots[p] = 7'd2;
        end
        3: begin
          layout_origin = '0;
          for (int p = 0; p < CFG_POOLS; p++) layout_slots[p] = 7'd64;
        end
        default: begin
          layout_origin = {$urandom, $urandom};
          for (int p = 0; p < CFG_POOLS; p++) layout_slots[p] = random_slots();
        end
      endcase
      load_layout();
      if (ph == 0) begin
        // Empty pool, a one-page pool filling up, and a saturated count.
        push_request(MODE_ALLOC, 3'd0, '0);
        push_request(MODE_ALLOC, 3'd1, '0);
        push_request(MODE_ALLOC, 3'd1, '0);
        push_request(MODE_ALLOC, 3'd3, '0);
        push_request(MODE_FREE, 3'd1, layout_start(1));
      end
      focus_pool = $urandom_range(CFG_POOLS - 1);
      alloc_pct  = (ph % 2 == 1) ? 80 : 55;
      quiet     <= (ph == 4);
      repeat (180) random_request();
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests over %0d pool layouts; %0d results compared, %0d mismatches.",
             requests_sent, layouts_run + 1, results_checked, fail_count);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
sv/mppa_pkg.sv
sv/mppa_ram.sv
sv/mppa_layout.sv
sv/mppa_slot_unit.sv
sv/multi_pool_page_allocator.sv
dv/page_alloc_checker.sv
dv/tb.sv
